// File: src/rtsmd_pkg.sv
// Shared types and constants for the three-symbol RLE decoder.
// No dependencies; used by rtsmd_step, rtsmd_result_fifo and the top level.
package rtsmd_pkg;

	// Format constants
	localparam int HeaderBytes       = 8;
	localparam int SymShift          = 14;
	localparam int CountBits         = 7;
	localparam int OffsetBits        = 14 - CountBits;
	localparam int RunBias           = (2 + 1) - 2;
	localparam int DefaultLengthBits = 32;
	localparam int ResultFifoDepth   = 4;

	// Escape codes of the count and offset fields
	localparam logic [CountBits-1:0]  CntEscLong  = CountBits'(0);
	localparam logic [CountBits-1:0]  CntEscShort = CountBits'(1);
	localparam logic [OffsetBits-1:0] OffEscLong  = OffsetBits'(0);
	localparam logic [OffsetBits-1:0] OffEscShort = OffsetBits'(1);

	// Reset contents of the recently-used list
	localparam logic [7:0] SymInitCur = 8'h00;
	localparam logic [7:0] SymInitR0  = 8'h7F;
	localparam logic [7:0] SymInitR1  = 8'hFF;

	typedef enum logic [3:0] {
		PH_HEADER = 4'd0,
		PH_WORD   = 4'd1,
		PH_SYM    = 4'd2,
		PH_CNT2   = 4'd3,
		PH_CNT4   = 4'd4,
		PH_OFF2   = 4'd5,
		PH_OFF4   = 4'd6,
		PH_LIT    = 4'd7,
		PH_DONE   = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		SEL_KEEP   = 2'd0,
		SEL_SWAP   = 2'd1,
		SEL_OLDEST = 2'd2,
		SEL_FRESH  = 2'd3
	} sym_sel_t;

	// Parser state apart from the run length, whose width is a parameter
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  fbc;
		logic [15:0] token_word;
		logic [7:0]  cur_sym;
		logic [7:0]  recent0;
		logic [7:0]  recent1;
		logic [31:0] lit_rem;
		logic        pending_end;
	} parse_state_t;

	typedef struct packed {
		logic        stream_end;
		logic [32:0] repeat_count;
		logic [7:0]  data_byte;
	} result_t;

endpackage

// File: src/rtsmd_step.sv
// Next-state and result logic for one compressed byte.
// Depends on rtsmd_pkg.
module rtsmd_step #(
	parameter int LENGTH_BITS = rtsmd_pkg::DefaultLengthBits
) (
	input  rtsmd_pkg::parse_state_t   st,
	input  logic [LENGTH_BITS:0]      run_len,
	input  logic [7:0]                in_byte,
	output rtsmd_pkg::parse_state_t   st_nxt,
	output logic [LENGTH_BITS:0]      run_len_nxt,
	output rtsmd_pkg::result_t [1:0]  items,
	output logic [1:0]                n_items
);

	localparam logic [31:0] LenMask = 32'((33'd1 << LENGTH_BITS) - 33'd1);

	logic [4:0]  sh;
	logic [31:0] acc_c;
	logic [31:0] acc_o;
	logic        start_cnt;
	logic        start_off;
	logic        lit_chk;
	logic        close_tok;
	logic        close_slot;
	logic [rtsmd_pkg::CountBits-1:0]  cnt_f;
	logic [rtsmd_pkg::OffsetBits-1:0] off_f;
	rtsmd_pkg::result_t close_item;

	assign sh    = {st.fbc[1:0], 3'b000};
	assign acc_c = (32'(run_len) | (32'(in_byte) << sh)) & LenMask;
	assign acc_o = (st.lit_rem | (32'(in_byte) << sh)) & LenMask;

	always_comb begin
		st_nxt      = st;
		run_len_nxt = run_len;
		items       = '0;
		n_items     = 2'd0;
		start_cnt   = 1'b0;
		start_off   = 1'b0;
		lit_chk     = 1'b0;
		close_tok   = 1'b0;
		close_slot  = 1'b0;
		cnt_f       = '0;
		off_f       = '0;
		close_item  = '0;

		unique case (st.phase)
			rtsmd_pkg::PH_HEADER: begin
				st_nxt.fbc = st.fbc + 3'd1;
				if (st.fbc == 3'(rtsmd_pkg::HeaderBytes - 1)) begin
					st_nxt.fbc   = 3'd0;
					st_nxt.phase = rtsmd_pkg::PH_WORD;
				end
			end
			rtsmd_pkg::PH_WORD: begin
				if (st.fbc == 3'd0) begin
					st_nxt.token_word = {8'h00, in_byte};
					st_nxt.fbc        = 3'd1;
				end else begin
					st_nxt.token_word = {in_byte, st.token_word[7:0]};
					st_nxt.fbc        = 3'd0;
					unique case (rtsmd_pkg::sym_sel_t'(in_byte[7:6]))
						rtsmd_pkg::SEL_FRESH: begin
							st_nxt.phase = rtsmd_pkg::PH_SYM;
						end
						rtsmd_pkg::SEL_OLDEST: begin
							st_nxt.cur_sym = st.recent1;
							st_nxt.recent1 = st.recent0;
							st_nxt.recent0 = st.cur_sym;
							start_cnt      = 1'b1;
						end
						rtsmd_pkg::SEL_SWAP: begin
							st_nxt.cur_sym = st.recent0;
							st_nxt.recent0 = st.cur_sym;
							start_cnt      = 1'b1;
						end
						default: begin
							start_cnt = 1'b1;
						end
					endcase
				end
			end
			rtsmd_pkg::PH_SYM: begin
				st_nxt.recent1 = st.recent0;
				st_nxt.recent0 = st.cur_sym;
				st_nxt.cur_sym = in_byte;
				start_cnt      = 1'b1;
			end
			rtsmd_pkg::PH_CNT2, rtsmd_pkg::PH_CNT4: begin
				run_len_nxt = (LENGTH_BITS + 1)'(acc_c);
				st_nxt.fbc  = st.fbc + 3'd1;
				if ((st.phase == rtsmd_pkg::PH_CNT2 && st.fbc == 3'd1) ||
				    (st.phase == rtsmd_pkg::PH_CNT4 && st.fbc == 3'd3)) begin
					// zero extension: literals still pass, then end marker
					if (acc_c == 32'd0)
						st_nxt.pending_end = 1'b1;
					else
						run_len_nxt = (LENGTH_BITS + 1)'(acc_c) +
						              (LENGTH_BITS + 1)'(rtsmd_pkg::RunBias);
					start_off = 1'b1;
				end
			end
			rtsmd_pkg::PH_OFF2, rtsmd_pkg::PH_OFF4: begin
				st_nxt.lit_rem = acc_o;
				st_nxt.fbc     = st.fbc + 3'd1;
				if ((st.phase == rtsmd_pkg::PH_OFF2 && st.fbc == 3'd1) ||
				    (st.phase == rtsmd_pkg::PH_OFF4 && st.fbc == 3'd3)) begin
					if (acc_o == 32'd0) begin
						// zero offset extension ends the stream at once
						items[0].data_byte    = 8'h00;
						items[0].repeat_count = 33'd0;
						items[0].stream_end   = 1'b1;
						n_items               = 2'd1;
						st_nxt.phase          = rtsmd_pkg::PH_DONE;
					end else begin
						st_nxt.lit_rem = acc_o - 32'd2;
						lit_chk        = 1'b1;
					end
				end
			end
			rtsmd_pkg::PH_LIT: begin
				items[0].data_byte    = in_byte;
				items[0].repeat_count = 33'd1;
				items[0].stream_end   = 1'b0;
				n_items               = 2'd1;
				st_nxt.lit_rem        = st.lit_rem - 32'd1;
				if (st.lit_rem == 32'd1) begin
					close_tok  = 1'b1;
					close_slot = 1'b1;
				end
			end
			default: begin
				// after the end marker every byte is dropped
			end
		endcase

		// token header decoded: count field
		if (start_cnt) begin
			cnt_f              = st_nxt.token_word[rtsmd_pkg::OffsetBits +: rtsmd_pkg::CountBits];
			st_nxt.fbc         = 3'd0;
			st_nxt.pending_end = 1'b0;
			if (cnt_f == rtsmd_pkg::CntEscLong) begin
				run_len_nxt  = '0;
				st_nxt.phase = rtsmd_pkg::PH_CNT4;
			end else if (cnt_f == rtsmd_pkg::CntEscShort) begin
				run_len_nxt  = '0;
				st_nxt.phase = rtsmd_pkg::PH_CNT2;
			end else begin
				run_len_nxt = (LENGTH_BITS + 1)'(cnt_f) +
				              (LENGTH_BITS + 1)'(rtsmd_pkg::RunBias);
				start_off   = 1'b1;
			end
		end

		// offset field
		if (start_off) begin
			off_f      = st_nxt.token_word[rtsmd_pkg::OffsetBits-1:0];
			st_nxt.fbc = 3'd0;
			if (off_f == rtsmd_pkg::OffEscLong) begin
				st_nxt.lit_rem = 32'd0;
				st_nxt.phase   = rtsmd_pkg::PH_OFF4;
			end else if (off_f == rtsmd_pkg::OffEscShort) begin
				st_nxt.lit_rem = 32'd0;
				st_nxt.phase   = rtsmd_pkg::PH_OFF2;
			end else begin
				st_nxt.lit_rem = 32'(off_f) - 32'd2;
				lit_chk        = 1'b1;
			end
		end

		if (lit_chk) begin
			if (st_nxt.lit_rem == 32'd0)
				close_tok = 1'b1;
			else
				st_nxt.phase = rtsmd_pkg::PH_LIT;
		end

		// run item or end marker once the literals are through
		if (close_tok) begin
			if (st_nxt.pending_end) begin
				close_item.data_byte    = 8'h00;
				close_item.repeat_count = 33'd0;
				close_item.stream_end   = 1'b1;
				st_nxt.phase            = rtsmd_pkg::PH_DONE;
			end else begin
				close_item.data_byte    = st_nxt.cur_sym;
				close_item.repeat_count = 33'(run_len_nxt);
				close_item.stream_end   = 1'b0;
				st_nxt.phase            = rtsmd_pkg::PH_WORD;
				st_nxt.fbc              = 3'd0;
			end
			if (close_slot) begin
				items[1] = close_item;
				n_items  = 2'd2;
			end else begin
				items[0] = close_item;
				n_items  = 2'd1;
			end
		end
	end

endmodule

// File: src/rtsmd_result_fifo.sv
// Small result queue: up to two writes and one read per cycle.
// Depends on rtsmd_pkg.
module rtsmd_result_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rtsmd_pkg::result_t [1:0]  push_item,
	input  logic [1:0]                push_n,
	output logic                      room2,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rtsmd_pkg::result_t        out_item
);

	localparam int Depth   = rtsmd_pkg::ResultFifoDepth;
	localparam int PtrBits = $clog2(Depth);

	rtsmd_pkg::result_t mem_q [Depth];
	logic [PtrBits-1:0] wr_q;
	logic [PtrBits-1:0] rd_q;
	logic [PtrBits:0]   count_q;
	logic [PtrBits-1:0] wr_nxt1;
	logic               pop;

	assign wr_nxt1   = wr_q + PtrBits'(1);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_item  = mem_q[rd_q];
	assign room2     = (count_q <= (PtrBits + 1)'(Depth - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_q] <= push_item[0];
		if (push_n == 2'd2)
			mem_q[wr_nxt1] <= push_item[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PtrBits'(push_n);
			rd_q    <= rd_q + PtrBits'(pop);
			count_q <= count_q + (PtrBits + 1)'(push_n) - (PtrBits + 1)'(pop);
		end
	end

endmodule

// File: src/rle_three_symbol_mtf_decoder_unit.sv
// Three-symbol RLE stream decoder: one compressed byte in per cycle, literal and
// run requests out. A new byte is taken every cycle while the four-entry result
// queue has room for two results; each byte is parsed by the combinational step
// logic into the parser registers and the queue. The first eight bytes are
// a size header and are dropped. Each token then yields its literal bytes as
// they arrive (repeat count 1) and one run request (symbol, count + 1). The
// stream ends with a request carrying repeat count 0 and tlast high; every byte
// after it is accepted and dropped until reset. Rate: one byte per cycle while the
// queue has room for two results; the output side drains one request per cycle,
// so back-pressure on m_tready alone holds off s_tready.
// Depends on rtsmd_pkg, rtsmd_step and rtsmd_result_fifo.
module rle_three_symbol_mtf_decoder_unit #(
	parameter int LENGTH_BITS = rtsmd_pkg::DefaultLengthBits
) (
	input  logic        clk,
	input  logic        arst_n,
	// compressed byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// decoded requests
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] data_byte, [40:8] repeat_count, rest zero
	output logic        m_tlast    // stream_end
);

	rtsmd_pkg::parse_state_t  st_q;
	rtsmd_pkg::parse_state_t  st_nxt;
	logic [LENGTH_BITS:0]     run_q;
	logic [LENGTH_BITS:0]     run_nxt;
	rtsmd_pkg::result_t [1:0] items;
	logic [1:0]               n_items;
	logic [1:0]               push_n;
	logic                     room2;
	logic                     accept;
	rtsmd_pkg::result_t       out_item;

	assign s_tready = room2;
	assign accept   = s_tvalid & s_tready;
	assign push_n   = accept ? n_items : 2'd0;

	// all parsing for one byte happens here
	rtsmd_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.st          (st_q),
		.run_len     (run_q),
		.in_byte     (s_tdata),
		.st_nxt      (st_nxt),
		.run_len_nxt (run_nxt),
		.items       (items),
		.n_items     (n_items)
	);

	// parser state only moves on an accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= rtsmd_pkg::PH_HEADER;
			st_q.fbc         <= 3'd0;
			st_q.token_word  <= 16'd0;
			st_q.cur_sym     <= rtsmd_pkg::SymInitCur;
			st_q.recent0     <= rtsmd_pkg::SymInitR0;
			st_q.recent1     <= rtsmd_pkg::SymInitR1;
			st_q.lit_rem     <= 32'd0;
			st_q.pending_end <= 1'b0;
			run_q            <= '0;
		end else if (accept) begin
			st_q  <= st_nxt;
			run_q <= run_nxt;
		end
	end

	// results wait here so a stalled consumer does not block the parser until the queue lacks room for two
	rtsmd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_item (items),
		.push_n    (push_n),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = {7'd0, out_item.repeat_count, out_item.data_byte};
	assign m_tlast = out_item.stream_end;

endmodule
